// ===== rtl/pqwc_pkg.sv =====
// package for the print queue with cancel: widths, command and status codes,
// cell control types and the name trimming function
// no dependencies

package pqwc_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int NAME_BYTES = 24;
  localparam int NAME_W     = 8 * NAME_BYTES;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = 200;

  typedef logic [NAME_W-1:0] name_t;

  // command codes
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // command broadcast to every cell
  typedef struct packed {
    logic push;
    logic shift_all;
    logic cancel;
    logic rotate;
  } cell_op_t;

  // where a cell sits relative to the fill level
  typedef struct packed {
    logic valid;
    logic at_free;
    logic at_last;
  } cell_pos_t;

  // clear every byte after the first zero byte
  function automatic name_t trim_name(input name_t n);
    logic  ended;
    name_t r;
    ended = 1'b0;
    r     = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (n[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[8*b +: 8] = n[8*b +: 8];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pqwc_cell.sv =====
// one queue slot: holds a name, compares it with the cancel key and takes
// data from the input, its upper neighbor or the head; uses pqwc_pkg

module pqwc_cell (
  input  logic               clk,
  input  pqwc_pkg::cell_op_t op,
  input  pqwc_pkg::cell_pos_t pos,
  input  pqwc_pkg::name_t    in_name,
  input  pqwc_pkg::name_t    next_name,
  input  pqwc_pkg::name_t    head_name,
  input  pqwc_pkg::name_t    key,
  input  logic               found_in,
  output logic               found_out,
  output pqwc_pkg::name_t    data
);

  pqwc_pkg::name_t data_r;
  pqwc_pkg::name_t data_nxt;
  logic            hit;

  // first match ripples up the chain
  assign hit       = pos.valid && (data_r == key);
  assign found_out = found_in | hit;
  assign data      = data_r;

  // slot load select
  always_comb begin
    data_nxt = data_r;
    if (op.push && pos.at_free) begin
      data_nxt = in_name;
    end else if (op.shift_all || (op.cancel && found_out)) begin
      data_nxt = next_name;
    end else if (op.rotate && pos.valid) begin
      data_nxt = pos.at_last ? head_name : next_name;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== rtl/print_queue_with_cancel_top.sv =====
// top level of the print queue with cancel: command decode, fill count,
// list sequencer and output register over a chain of pqwc_cell slots
// uses pqwc_pkg and pqwc_cell

// Print queue of up to DEPTH names of 24 bytes, kept packed with the oldest
// in the first cell. Push, pop, head and cancel each give one result beat;
// cancel compares the key in every cell at once, and the first matching cell
// and every cell above it take their upper neighbor's name. List gives one
// beat per entry, one per cycle while the output register is free, by
// rotating the chain through the head; the accepting cycle gives no beat,
// and no command is taken until its last beat is in the output register.
// A name ends at its first zero byte; later bytes are cleared before
// storing or comparing. Kinds 5 to 7 are dropped without a result. While a
// result beat waits in the output register no command is taken; a new
// command goes in during the cycle in which that beat leaves.

module print_queue_with_cancel_top #(
  parameter int DEPTH = pqwc_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pqwc_pkg::NAME_W-1:0]     in_tdata,   // name_word0, name_word1, name_word2
  input  logic [pqwc_pkg::KIND_W-1:0]     in_tuser,   // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pqwc_pkg::OUT_DATA_W-1:0] out_tdata,  // status, out_word0, out_word1, out_word2
  output logic                            out_tlast   // last
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic                          state_r, state_nxt;
  logic [OCC_W-1:0]              occ_r, occ_nxt;
  logic [OCC_W-1:0]              cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_last_r;
  logic [pqwc_pkg::STATUS_W-1:0] out_status_r;
  pqwc_pkg::name_t               out_name_r;

  logic                          slot_free;
  logic                          in_acc;
  pqwc_pkg::name_t               key;
  pqwc_pkg::cell_op_t            op;
  pqwc_pkg::cell_pos_t           pos   [DEPTH];
  pqwc_pkg::name_t               cdata [DEPTH];
  logic [DEPTH:0]                found;
  logic                          any_hit;

  logic                          emit;
  logic [pqwc_pkg::STATUS_W-1:0] em_status;
  pqwc_pkg::name_t               em_name;
  logic                          em_last;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;
  assign key       = pqwc_pkg::trim_name(in_tdata);
  assign found[0]  = 1'b0;
  assign any_hit   = found[DEPTH];

  // chain of slots
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign pos[i].valid   = (OCC_W'(i) < occ_r);
    assign pos[i].at_free = (OCC_W'(i) == occ_r);
    assign pos[i].at_last = (OCC_W'(i + 1) == occ_r);

    pqwc_cell u_cell (
      .clk       (clk),
      .op        (op),
      .pos       (pos[i]),
      .in_name   (key),
      .next_name ((i + 1 < DEPTH) ? cdata[(i + 1) % DEPTH] : cdata[i]),
      .head_name (cdata[0]),
      .key       (key),
      .found_in  (found[i]),
      .found_out (found[i + 1]),
      .data      (cdata[i])
    );
  end

  // command decode and list sequencing
  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    cnt_nxt   = cnt_r;
    op        = '0;
    emit      = 1'b0;
    em_status = pqwc_pkg::ST_OK;
    em_name   = '0;
    em_last   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            pqwc_pkg::KIND_PUSH: begin
              emit = 1'b1;
              if (occ_r == OCC_W'(DEPTH)) begin
                em_status = pqwc_pkg::ST_FULL;
              end else begin
                op.push = 1'b1;
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            pqwc_pkg::KIND_POP, pqwc_pkg::KIND_HEAD: begin
              emit = 1'b1;
              if (occ_r == '0) begin
                em_status = pqwc_pkg::ST_EMPTY;
              end else begin
                em_name = cdata[0];
                if (in_tuser == pqwc_pkg::KIND_POP) begin
                  op.shift_all = 1'b1;
                  occ_nxt      = occ_r - OCC_W'(1);
                end
              end
            end
            pqwc_pkg::KIND_CANCEL: begin
              emit = 1'b1;
              if (occ_r == '0) begin
                em_status = pqwc_pkg::ST_EMPTY;
              end else if (any_hit) begin
                op.cancel = 1'b1;
                occ_nxt   = occ_r - OCC_W'(1);
              end else begin
                em_status = pqwc_pkg::ST_NOTFOUND;
              end
            end
            pqwc_pkg::KIND_LIST: begin
              if (occ_r == '0) begin
                emit      = 1'b1;
                em_status = pqwc_pkg::ST_EMPTY;
              end else begin
                state_nxt = ST_LIST;
                cnt_nxt   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          emit      = 1'b1;
          em_name   = cdata[0];
          em_last   = (cnt_r + OCC_W'(1) == occ_r);
          op.rotate = 1'b1;
          cnt_nxt   = cnt_r + OCC_W'(1);
          if (em_last) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= em_status;
      out_name_r   <= em_name;
      out_last_r   <= em_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(pqwc_pkg::OUT_DATA_W - pqwc_pkg::NAME_W - pqwc_pkg::STATUS_W){1'b0}},
                       out_name_r, out_status_r};

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("fill count above depth");

  a_list_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |=> (occ_r == $past(occ_r)))
    else $error("fill count changed during list");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST && emit && em_last) |=> (state_r == ST_IDLE))
    else $error("list did not end after last beat");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("result written over a waiting beat");

endmodule

// ===== test/print_queue_with_cancel_top_tb.sv =====
// testbench for print_queue_with_cancel_top: directed and random job commands
// checked beat by beat against a queue model kept in the bench
// depends on pqwc_pkg and the print_queue_with_cancel_top rtl
`timescale 1ns / 100ps

module print_queue_with_cancel_top_tb;

  localparam int CLK_PERIOD  = 8;
  localparam int JOB_SLOTS   = pqwc_pkg::DEPTH_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 90;

  typedef struct {
    logic [pqwc_pkg::STATUS_W-1:0] status;
    pqwc_pkg::name_t               name;
    logic                          last;
  } reply_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pqwc_pkg::NAME_W-1:0]     in_tdata = '0;   // name_word0, name_word1, name_word2
  logic [pqwc_pkg::KIND_W-1:0]     in_tuser = '0;   // kind
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pqwc_pkg::OUT_DATA_W-1:0] out_tdata;       // status, out_word0, out_word1, out_word2
  logic                            out_tlast;       // last

  // bench model of the queue and the replies still owed
  pqwc_pkg::name_t jobs[$];
  reply_t          replies_due[$];

  int  errors = 0;
  int  beats_checked = 0;
  int  cmd_count[8];
  int  full_pushes = 0;
  int  cancel_misses = 0;
  int  deepest = 0;
  int  quiet_cycles = 0;
  int  hold_req = 0;
  bit  calm = 1'b0;
  pqwc_pkg::name_t pool_name[8];
  int              pool_len[8];

  print_queue_with_cancel_top #(
    .DEPTH(JOB_SLOTS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // a name ends at its first zero byte, the rest is dropped
  function automatic pqwc_pkg::name_t clip_at_nul(pqwc_pkg::name_t raw);
    pqwc_pkg::name_t keep;
    logic            live;
    keep = '0;
    live = 1'b1;
    for (int i = 0; i < pqwc_pkg::NAME_BYTES; i++) begin
      live = live && (raw[8*i +: 8] != 8'h00);
      if (live) keep[8*i +: 8] = raw[8*i +: 8];
    end
    return keep;
  endfunction

  function automatic pqwc_pkg::name_t random_name(int len);
    pqwc_pkg::name_t n;
    n = '0;
    for (int i = 0; i < len; i++) n[8*i +: 8] = 8'($urandom_range(1, 255));
    return n;
  endfunction

  // random bytes behind the terminator, which the block must ignore
  function automatic pqwc_pkg::name_t smear_tail(pqwc_pkg::name_t n, int len);
    pqwc_pkg::name_t r;
    r = n;
    for (int i = len + 1; i < pqwc_pkg::NAME_BYTES; i++) r[8*i +: 8] = 8'($urandom);
    return r;
  endfunction

  function automatic pqwc_pkg::name_t pooled_name();
    int i;
    i = $urandom_range(0, 7);
    if ($urandom_range(0, 1) == 1) return smear_tail(pool_name[i], pool_len[i]);
    return pool_name[i];
  endfunction

  function automatic void owe_reply(logic [pqwc_pkg::STATUS_W-1:0] st,
                                    pqwc_pkg::name_t n, logic lst);
    reply_t r;
    r.status = st;
    r.name   = n;
    r.last   = lst;
    replies_due.push_back(r);
  endfunction

  // update the queue model for one accepted command and queue its replies
  function automatic void predict_command(logic [pqwc_pkg::KIND_W-1:0] kind,
                                          pqwc_pkg::name_t raw);
    pqwc_pkg::name_t key;
    int              hit;
    key = clip_at_nul(raw);
    hit = -1;
    cmd_count[kind]++;
    case (kind)
      pqwc_pkg::KIND_PUSH: begin
        if (jobs.size() >= JOB_SLOTS) begin
          full_pushes++;
          owe_reply(pqwc_pkg::ST_FULL, '0, 1'b1);
        end else begin
          jobs.push_back(key);
          owe_reply(pqwc_pkg::ST_OK, '0, 1'b1);
        end
      end
      pqwc_pkg::KIND_POP, pqwc_pkg::KIND_HEAD: begin
        if (jobs.size() == 0) begin
          owe_reply(pqwc_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          owe_reply(pqwc_pkg::ST_OK, jobs[0], 1'b1);
          if (kind == pqwc_pkg::KIND_POP) void'(jobs.pop_front());
        end
      end
      pqwc_pkg::KIND_CANCEL: begin
        if (jobs.size() == 0) begin
          owe_reply(pqwc_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (jobs[i]) if (hit < 0 && jobs[i] == key) hit = i;
          if (hit >= 0) begin
            jobs.delete(hit);
            owe_reply(pqwc_pkg::ST_OK, '0, 1'b1);
          end else begin
            cancel_misses++;
            owe_reply(pqwc_pkg::ST_NOTFOUND, '0, 1'b1);
          end
        end
      end
      pqwc_pkg::KIND_LIST: begin
        if (jobs.size() == 0) owe_reply(pqwc_pkg::ST_EMPTY, '0, 1'b1);
        else foreach (jobs[i]) owe_reply(pqwc_pkg::ST_OK, jobs[i], i == jobs.size() - 1);
      end
      default: ;
    endcase
    if (jobs.size() > deepest) deepest = jobs.size();
  endfunction

  // compare one result beat with the oldest owed reply
  function automatic void check_beat();
    reply_t          want;
    pqwc_pkg::name_t got_name;
    got_name = out_tdata[pqwc_pkg::STATUS_W +: pqwc_pkg::NAME_W];
    beats_checked++;
    if (replies_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat, expected none, actual status %0d name %h last %b",
               $time, out_tdata[pqwc_pkg::STATUS_W-1:0], got_name, out_tlast);
      return;
    end
    want = replies_due.pop_front();
    if (out_tdata[pqwc_pkg::STATUS_W-1:0] !== want.status) begin
      errors++;
      $display("%0t: status mismatch, expected %0d actual %0d",
               $time, want.status, out_tdata[pqwc_pkg::STATUS_W-1:0]);
    end
    for (int w = 0; w < 3; w++) begin
      if (got_name[64*w +: 64] !== want.name[64*w +: 64]) begin
        errors++;
        $display("%0t: out_word%0d mismatch, expected %h actual %h",
                 $time, w, want.name[64*w +: 64], got_name[64*w +: 64]);
      end
    end
    if (out_tlast !== want.last) begin
      errors++;
      $display("%0t: last mismatch, expected %b actual %b", $time, want.last, out_tlast);
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_beat();
  end

  // result side ready: random stalls, plus long holds on request
  initial begin : sink
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rst_n && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // offer one command, with an optional idle burst first, until it is taken
  task automatic send_command(logic [pqwc_pkg::KIND_W-1:0] kind, pqwc_pkg::name_t raw);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_command(kind, raw);
  endtask

  // stop offering until every owed reply has come back
  task automatic wait_all_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // pop, head, cancel and list on an empty queue
  task automatic test_empty_queue();
    send_command(pqwc_pkg::KIND_POP, '0);
    send_command(pqwc_pkg::KIND_HEAD, '0);
    send_command(pqwc_pkg::KIND_CANCEL, random_name(3));
    send_command(pqwc_pkg::KIND_LIST, '0);
  endtask

  // extreme names, junk after the terminator, unknown kinds, cancel at head
  task automatic test_names_and_cancel();
    pqwc_pkg::name_t a_clean;
    a_clean = random_name(5);
    send_command(pqwc_pkg::KIND_PUSH, {pqwc_pkg::NAME_W{1'b1}});
    send_command(pqwc_pkg::KIND_PUSH, smear_tail(a_clean, 5));
    send_command(pqwc_pkg::KIND_PUSH, '0);
    send_command(pqwc_pkg::KIND_PUSH, pqwc_pkg::name_t'(8'h41));
    send_command(pqwc_pkg::KIND_HEAD, '0);
    send_command(pqwc_pkg::KIND_LIST, '0);
    for (int k = 5; k < 8; k++) send_command(pqwc_pkg::KIND_W'(k), {6{$urandom}});
    send_command(pqwc_pkg::KIND_CANCEL, {pqwc_pkg::NAME_W{1'b1}});
    send_command(pqwc_pkg::KIND_CANCEL, smear_tail(a_clean, 5));
    send_command(pqwc_pkg::KIND_CANCEL, random_name(pqwc_pkg::NAME_BYTES));
    send_command(pqwc_pkg::KIND_CANCEL, '0);
    send_command(pqwc_pkg::KIND_POP, '0);
    send_command(pqwc_pkg::KIND_POP, '0);
  endtask

  // receiver holds off while pushes pile up past full, then a full list
  task automatic test_full_and_backpressure();
    hold_req = LONG_HOLD;
    for (int i = 0; i <= JOB_SLOTS; i++)
      send_command(pqwc_pkg::KIND_PUSH, random_name($urandom_range(1, pqwc_pkg::NAME_BYTES)));
    send_command(pqwc_pkg::KIND_LIST, '0);
    wait_all_replies();
  endtask

  // mixed traffic with fill and drain phases, keys mostly from live entries
  task automatic test_random_traffic(int n, bit steady);
    int                          sent;
    int                          roll;
    int                          push_pct;
    bit                          fill_phase;
    logic [pqwc_pkg::KIND_W-1:0] kind;
    pqwc_pkg::name_t             raw;
    sent       = 0;
    fill_phase = 1'b1;
    calm       = steady;
    while (sent < n) begin
      if (sent % 30 == 29) fill_phase = !fill_phase;
      push_pct = fill_phase ? 55 : 15;
      roll     = $urandom_range(0, 99);
      raw      = '0;
      if (roll < 3) begin
        kind = pqwc_pkg::KIND_W'($urandom_range(5, 7));
        raw  = {6{$urandom}};
      end else if (roll < 3 + push_pct) begin
        kind = pqwc_pkg::KIND_PUSH;
        if ($urandom_range(0, 9) == 0) raw = random_name($urandom_range(0, pqwc_pkg::NAME_BYTES));
        else raw = pooled_name();
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 25) kind = pqwc_pkg::KIND_POP;
        else if (roll < 40) kind = pqwc_pkg::KIND_HEAD;
        else if (roll < 80) kind = pqwc_pkg::KIND_CANCEL;
        else kind = pqwc_pkg::KIND_LIST;
        if (kind == pqwc_pkg::KIND_CANCEL) begin
          roll = $urandom_range(0, 99);
          if (roll < 60 && jobs.size() != 0) raw = jobs[$urandom_range(0, jobs.size() - 1)];
          else if (roll < 85) raw = pooled_name();
          else raw = random_name($urandom_range(0, pqwc_pkg::NAME_BYTES));
        end else begin
          raw = {6{$urandom}};
        end
      end
      // refresh the name pool now and then
      if ($urandom_range(0, 19) == 0) begin
        roll = $urandom_range(0, 7);
        pool_len[roll]  = $urandom_range(0, pqwc_pkg::NAME_BYTES);
        pool_name[roll] = random_name(pool_len[roll]);
      end
      send_command(kind, raw);
      if (kind <= pqwc_pkg::KIND_LIST) sent++;
    end
  endtask

  initial begin : main
    foreach (cmd_count[k]) cmd_count[k] = 0;
    for (int i = 0; i < 8; i++) begin
      pool_len[i]  = (i < 2) ? pqwc_pkg::NAME_BYTES : $urandom_range(1, 12);
      pool_name[i] = random_name(pool_len[i]);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_names_and_cancel();
    test_full_and_backpressure();
    test_random_traffic(95, 1'b0);
    test_random_traffic(30, 1'b1);

    // drain, then allow for any stray beats
    wait_all_replies();
    repeat (JOB_SLOTS + 8) @(posedge clk);

    $display("ran %0d push, %0d pop, %0d head, %0d cancel, %0d list, %0d unknown commands",
             cmd_count[pqwc_pkg::KIND_PUSH], cmd_count[pqwc_pkg::KIND_POP],
             cmd_count[pqwc_pkg::KIND_HEAD], cmd_count[pqwc_pkg::KIND_CANCEL],
             cmd_count[pqwc_pkg::KIND_LIST],
             cmd_count[5] + cmd_count[6] + cmd_count[7]);
    $display("checked %0d beats, %0d pushes on a full queue, %0d missed cancels, depth %0d",
             beats_checked, full_pushes, cancel_misses, deepest);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pqwc_pkg.sv
rtl/pqwc_cell.sv
rtl/print_queue_with_cancel_top.sv
test/print_queue_with_cancel_top_tb.sv
